[hdl/gbpe_pkg.sv]
// ----------------------------------------------------------------------------
// gbpe_pkg
// Types, register map and reset values shared by the glyph bitmap expander.
// ----------------------------------------------------------------------------
`default_nettype none

package gbpe_pkg;

	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_ORIGIN_X     = 3'd0,
		REG_ORIGIN_Y     = 3'd1,
		REG_GLYPH_WIDTH  = 3'd2,
		REG_GLYPH_HEIGHT = 3'd3,
		REG_X_OFFSET     = 3'd4,
		REG_Y_OFFSET     = 3'd5,
		REG_DRAW_COLOR   = 3'd6
	} reg_idx_t;

	localparam logic [11:0] RST_ORIGIN_X     = 12'd0;
	localparam logic [11:0] RST_ORIGIN_Y     = 12'd0;
	localparam logic [7:0]  RST_GLYPH_WIDTH  = 8'd8;
	localparam logic [7:0]  RST_GLYPH_HEIGHT = 8'd16;
	localparam logic [7:0]  RST_X_OFFSET     = 8'd0;
	localparam logic [7:0]  RST_Y_OFFSET     = 8'd0;
	localparam logic [31:0] RST_DRAW_COLOR   = 32'd0;

	localparam logic [13:0] CELL_BOTTOM = 14'd15;

	typedef struct packed {
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [7:0]  glyph_width;
		logic [7:0]  glyph_height;
		logic [7:0]  x_offset;
		logic [7:0]  y_offset;
		logic [31:0] draw_color;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  pixels;
		logic [13:0] base_x;
		logic [13:0] pixel_y;
		logic        glyph_done;
	} entry_t;

endpackage

`default_nettype wire

[hdl/gbpe_if.sv]
// ----------------------------------------------------------------------------
// gbpe channel interfaces
// Bitmap byte channel and pixel write channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbpe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] bitmap_byte;

	modport source (output valid, output bitmap_byte, input ready);
	modport sink   (input valid, input bitmap_byte, output ready);
endinterface

interface gbpe_pixel_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] pixel_x;
	logic signed [13:0] pixel_y;
	logic        [31:0] pixel_color;
	logic               last_of_byte;
	logic               glyph_done;
	logic signed [9:0]  advance_width;

	modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
		output last_of_byte, output glyph_done, output advance_width, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
		input last_of_byte, input glyph_done, input advance_width, output ready);
endinterface

`default_nettype wire

[hdl/glyph_bitmap_pixel_expander.sv]
// ----------------------------------------------------------------------------
// glyph_bitmap_pixel_expander
// Expands 1bpp glyph bitmap bytes into pixel write words.
//
//   channel     dir   handshake            payload
//   bitmap_in   in    valid/ready          bitmap_byte
//   pixel_out   out   valid/ready          pixel_x, pixel_y, pixel_color,
//                                          last_of_byte, glyph_done, advance_width
//   apb         in    psel/penable/pready  paddr, pwdata, prdata
//
// front end takes one byte per cycle while the queue has room
// back end issues one pixel word per cycle while the output is not stalled:
// a byte yields one word per set bit, and bytes with no set bits are not queued
// a taken byte passes the queue, then the work register, then the output register
// reset clears counters, queue pointers and output valid; no clearing pass
// a stalled output holds its word while the back end waits
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_bitmap_pixel_expander #(
	parameter int QUEUE_DEPTH = gbpe_pkg::QUEUE_DEPTH
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [gbpe_pkg::ADDR_W-1:0] paddr,
	input  wire  [gbpe_pkg::DATA_W-1:0] pwdata,
	output logic [gbpe_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	gbpe_byte_if.sink                   bitmap_in,
	gbpe_pixel_if.source                pixel_out
);

	gbpe_pkg::cfg_t   cfg;
	gbpe_pkg::entry_t push_entry;
	gbpe_pkg::entry_t pop_entry;
	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_valid;

	gbpe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gbpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.bitmap_in (bitmap_in),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (push_entry)
	);

	gbpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.entry_in  (push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.entry_out (pop_entry)
	);

	gbpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_entry   (pop_entry),
		.q_pop     (q_pop),
		.pixel_out (pixel_out)
	);

endmodule

`default_nettype wire

[hdl/gbpe_cfg.sv]
// ----------------------------------------------------------------------------
// gbpe_cfg
// APB register bank holding glyph geometry, origin and colour.
// ----------------------------------------------------------------------------
`default_nettype none

module gbpe_cfg (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [gbpe_pkg::ADDR_W-1:0] paddr,
	input  wire  [gbpe_pkg::DATA_W-1:0] pwdata,
	output logic [gbpe_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output gbpe_pkg::cfg_t              cfg
);

	gbpe_pkg::cfg_t     cfg_q;
	gbpe_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = gbpe_pkg::reg_idx_t'(paddr[gbpe_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= gbpe_pkg::RST_ORIGIN_X;
			cfg_q.origin_y     <= gbpe_pkg::RST_ORIGIN_Y;
			cfg_q.glyph_width  <= gbpe_pkg::RST_GLYPH_WIDTH;
			cfg_q.glyph_height <= gbpe_pkg::RST_GLYPH_HEIGHT;
			cfg_q.x_offset     <= gbpe_pkg::RST_X_OFFSET;
			cfg_q.y_offset     <= gbpe_pkg::RST_Y_OFFSET;
			cfg_q.draw_color   <= gbpe_pkg::RST_DRAW_COLOR;
		end else if (wr_en) begin
			unique case (idx)
				gbpe_pkg::REG_ORIGIN_X:     cfg_q.origin_x     <= pwdata[11:0];
				gbpe_pkg::REG_ORIGIN_Y:     cfg_q.origin_y     <= pwdata[11:0];
				gbpe_pkg::REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= pwdata[7:0];
				gbpe_pkg::REG_GLYPH_HEIGHT: cfg_q.glyph_height <= pwdata[7:0];
				gbpe_pkg::REG_X_OFFSET:     cfg_q.x_offset     <= pwdata[7:0];
				gbpe_pkg::REG_Y_OFFSET:     cfg_q.y_offset     <= pwdata[7:0];
				gbpe_pkg::REG_DRAW_COLOR:   cfg_q.draw_color   <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			gbpe_pkg::REG_ORIGIN_X:     prdata = {20'd0, cfg_q.origin_x};
			gbpe_pkg::REG_ORIGIN_Y:     prdata = {20'd0, cfg_q.origin_y};
			gbpe_pkg::REG_GLYPH_WIDTH:  prdata = {24'd0, cfg_q.glyph_width};
			gbpe_pkg::REG_GLYPH_HEIGHT: prdata = {24'd0, cfg_q.glyph_height};
			gbpe_pkg::REG_X_OFFSET:     prdata = {24'd0, cfg_q.x_offset};
			gbpe_pkg::REG_Y_OFFSET:     prdata = {24'd0, cfg_q.y_offset};
			gbpe_pkg::REG_DRAW_COLOR:   prdata = cfg_q.draw_color;
			default:                    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[hdl/gbpe_front.sv]
// ----------------------------------------------------------------------------
// gbpe_front
// Takes bitmap bytes, tracks column and row, works out the pixel base
// position and queues bytes that carry set pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module gbpe_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  gbpe_pkg::cfg_t         cfg,
	gbpe_byte_if.sink              bitmap_in,
	input  wire                    q_full,
	output logic                   q_push,
	output gbpe_pkg::entry_t       q_entry
);

	logic [4:0]  byte_column_q;
	logic [7:0]  row_index_q;
	logic [8:0]  wsum;
	logic [5:0]  wbytes;
	logic        empty_glyph;
	logic        last_col;
	logic        last_row;
	logic        accept;

	assign wsum        = {1'b0, cfg.glyph_width} + 9'd7;
	assign wbytes      = wsum[8:3];
	assign empty_glyph = (wbytes == 6'd0) || (cfg.glyph_height == 8'd0);
	assign last_col    = ({1'b0, byte_column_q} + 6'd1) >= wbytes;
	assign last_row    = ({1'b0, row_index_q} + 9'd1) >= {1'b0, cfg.glyph_height};

	assign bitmap_in.ready = !q_full;
	assign accept          = bitmap_in.valid && !q_full;
	assign q_push          = accept && !empty_glyph && (bitmap_in.bitmap_byte != 8'd0);

	always_comb begin
		q_entry.pixels     = bitmap_in.bitmap_byte;
		q_entry.base_x     = {2'b00, cfg.origin_x} + {{6{cfg.x_offset[7]}}, cfg.x_offset}
			+ {6'd0, byte_column_q, 3'b000};
		q_entry.pixel_y    = {2'b00, cfg.origin_y} + gbpe_pkg::CELL_BOTTOM
			- {{6{cfg.y_offset[7]}}, cfg.y_offset} - {6'd0, cfg.glyph_height}
			+ {6'd0, row_index_q};
		q_entry.glyph_done = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_column_q <= '0;
			row_index_q   <= '0;
		end else if (accept && !empty_glyph) begin
			if (last_col) begin
				byte_column_q <= '0;
				row_index_q   <= last_row ? 8'd0 : row_index_q + 8'd1;
			end else begin
				byte_column_q <= byte_column_q + 5'd1;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/gbpe_queue.sv]
// ----------------------------------------------------------------------------
// gbpe_queue
// Short queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gbpe_queue #(
	parameter int DEPTH = gbpe_pkg::QUEUE_DEPTH
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  gbpe_pkg::entry_t       entry_in,
	output logic                   full,
	input  wire                    pop,
	output logic                   not_empty,
	output gbpe_pkg::entry_t       entry_out
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	gbpe_pkg::entry_t   slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign entry_out = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hdl/gbpe_back.sv]
// ----------------------------------------------------------------------------
// gbpe_back
// Walks the set pixels of each queued byte, msb first, and issues one
// pixel write word per cycle, while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbpe_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  gbpe_pkg::cfg_t         cfg,
	input  wire                    q_valid,
	input  gbpe_pkg::entry_t       q_entry,
	output logic                   q_pop,
	gbpe_pixel_if.source           pixel_out
);

	logic        work_valid_q;
	logic [7:0]  mask_q;
	logic [13:0] base_x_q;
	logic [13:0] pixel_y_q;
	logic        done_q;

	logic        out_valid_q;
	logic [13:0] out_x_q;
	logic [13:0] out_y_q;
	logic        out_last_q;
	logic        out_done_q;

	logic [2:0]  idx;
	logic [7:0]  remaining;
	logic        last_bit;
	logic        out_free;
	logic        emit;
	logic        load;

	// first set pixel from the left
	always_comb begin
		idx = 3'd0;
		for (int b = 0; b < 8; b++) begin
			if (mask_q[b]) begin
				idx = 3'(7 - b);
			end
		end
	end

	assign remaining = mask_q & ~(8'h80 >> idx);
	assign last_bit  = (remaining == 8'd0);
	assign out_free  = !out_valid_q || pixel_out.ready;
	assign emit      = work_valid_q && out_free;
	assign load      = !work_valid_q || (emit && last_bit);
	assign q_pop     = load && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				work_valid_q <= q_valid;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pixel_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			mask_q    <= q_entry.pixels;
			base_x_q  <= q_entry.base_x;
			pixel_y_q <= q_entry.pixel_y;
			done_q    <= q_entry.glyph_done;
		end else if (emit) begin
			mask_q <= remaining;
		end
		if (emit) begin
			out_x_q    <= base_x_q + {11'd0, idx};
			out_y_q    <= pixel_y_q;
			out_last_q <= last_bit;
			out_done_q <= done_q;
		end
	end

	assign pixel_out.valid         = out_valid_q;
	assign pixel_out.pixel_x       = out_x_q;
	assign pixel_out.pixel_y       = out_y_q;
	assign pixel_out.pixel_color   = cfg.draw_color;
	assign pixel_out.last_of_byte  = out_last_q;
	assign pixel_out.glyph_done    = out_done_q;
	assign pixel_out.advance_width = {{2{cfg.x_offset[7]}}, cfg.x_offset}
		+ {2'b00, cfg.glyph_width} + 10'd1;

endmodule

`default_nettype wire
